@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the verification checker of the project.
// Self-contained; included by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, switched off while reset is low.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent, switched off in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/dcss_pkg.sv @@
// Package for the seven-segment scanned down counter: payload types, constants
// and the segment and rate look-up functions. Depends on nothing.
package dcss_pkg;

	localparam int NUM_DIGITS = 4;
	localparam int SCAN_W     = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
	localparam int BCD_DIGITS = 5;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_SCAN = 1'b1
	} opcode_t;

	typedef struct packed {
		opcode_t    opcode;
		logic [9:0] adc_sample;
	} cmd_t;

	typedef struct packed {
		logic [6:0]  segments;
		logic [3:0]  digit_enable;
		logic [7:0]  level_bar;
		logic [15:0] count_value;
	} res_t;

	typedef struct packed {
		logic       tick;
		logic       scan;
		logic [9:0] sample;
	} step_t;

	typedef logic [BCD_DIGITS-1:0][3:0] bcd_t;

	localparam logic [SCAN_W-1:0] POS_LAST     = SCAN_W'(NUM_DIGITS - 1);
	localparam logic [15:0]       TIMER_RESET  = 16'd15535;
	localparam logic [15:0]       COUNT_RESET  = 16'd9999;
	localparam logic [15:0]       PERIOD_RESET = 16'd50000;
	localparam logic [6:0]        SEG_RESET    = 7'h3F;
	localparam bcd_t              BCD_RESET    = 20'h09999;
	localparam bcd_t              BCD_WRAP     = 20'h65535;

	function automatic logic [6:0] seg_pattern(input logic [3:0] digit);
		logic [6:0] pat;
		case (digit)
			4'd0:    pat = 7'h3F;
			4'd1:    pat = 7'h06;
			4'd2:    pat = 7'h5B;
			4'd3:    pat = 7'h4F;
			4'd4:    pat = 7'h66;
			4'd5:    pat = 7'h6D;
			4'd6:    pat = 7'h7D;
			4'd7:    pat = 7'h07;
			4'd8:    pat = 7'h7F;
			4'd9:    pat = 7'h6F;
			default: pat = 7'h3F;
		endcase
		return pat;
	endfunction

	function automatic logic [15:0] rate_from_sample(input logic [9:0] sample);
		logic [15:0] rate;
		if (sample <= 10'd100)      rate = 16'd5000;
		else if (sample <= 10'd200) rate = 16'd10000;
		else if (sample <= 10'd300) rate = 16'd15000;
		else if (sample <= 10'd400) rate = 16'd20000;
		else if (sample <= 10'd500) rate = 16'd25000;
		else if (sample <= 10'd600) rate = 16'd30000;
		else if (sample <= 10'd700) rate = 16'd35000;
		else if (sample <= 10'd800) rate = 16'd40000;
		else if (sample <= 10'd900) rate = 16'd45000;
		else                        rate = 16'd50000;
		return rate;
	endfunction

endpackage

@@ rtl/core/dcss_timer.sv @@
// Reload timer, tick period and down counter with a decimal shadow copy.
// Depends on dcss_pkg.
module dcss_timer (
	input  logic               clk,
	input  logic               arst_n,
	input  dcss_pkg::step_t    step,
	output logic [15:0]        count_value,
	output dcss_pkg::bcd_t     digits
);

	logic [15:0]    timer_q;
	logic [15:0]    period_q;
	logic [15:0]    count_q;
	dcss_pkg::bcd_t bcd_q;
	dcss_pkg::bcd_t bcd_next;

	// The decimal copy follows the binary counter, including its wrap to 65535.
	always_comb begin
		logic borrow;
		borrow = 1'b1;
		for (int i = 0; i < dcss_pkg::BCD_DIGITS; i++) begin
			if (borrow) begin
				if (bcd_q[i] == 4'd0) begin
					bcd_next[i] = 4'd9;
				end else begin
					bcd_next[i] = bcd_q[i] - 4'd1;
					borrow      = 1'b0;
				end
			end else begin
				bcd_next[i] = bcd_q[i];
			end
		end
		if (count_q == 16'd0) begin
			bcd_next = dcss_pkg::BCD_WRAP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q  <= dcss_pkg::TIMER_RESET;
			period_q <= dcss_pkg::PERIOD_RESET;
			count_q  <= dcss_pkg::COUNT_RESET;
			bcd_q    <= dcss_pkg::BCD_RESET;
		end else begin
			if (step.scan) begin
				period_q <= dcss_pkg::rate_from_sample(step.sample);
			end
			if (step.tick) begin
				if (timer_q == 16'hFFFF) begin
					timer_q <= ~period_q;
					count_q <= count_q - 16'd1;
					bcd_q   <= bcd_next;
				end else begin
					timer_q <= timer_q + 16'd1;
				end
			end
		end
	end

	assign count_value = count_q;
	assign digits      = bcd_q;

endmodule

@@ rtl/core/dcss_scan.sv @@
// Display scan: digit selection, segment pattern, digit enable and level bar.
// Depends on dcss_pkg.
module dcss_scan (
	input  logic                clk,
	input  logic                arst_n,
	input  dcss_pkg::step_t     step,
	input  dcss_pkg::bcd_t      digits,
	output logic [6:0]          segments,
	output logic [3:0]          digit_enable,
	output logic [7:0]          level_bar
);

	logic [dcss_pkg::SCAN_W-1:0] pos_q;
	logic [6:0]                  seg_q;
	logic [3:0]                  en_q;
	logic [7:0]                  bar_q;
	logic [3:0]                  digit;
	logic [2:0]                  bit_idx;
	logic [3:0]                  onehot;

	// Positions beyond the fifth decimal digit of a 16-bit value show zero.
	always_comb begin
		digit = 4'd0;
		for (int i = 0; i < dcss_pkg::BCD_DIGITS; i++) begin
			if (4'(pos_q) == 4'(i)) begin
				digit = digits[i];
			end
		end
		bit_idx = 3'(dcss_pkg::NUM_DIGITS - 1) - 3'(pos_q);
		onehot  = (bit_idx < 3'd4) ? (4'd1 << bit_idx[1:0]) : 4'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			seg_q <= dcss_pkg::SEG_RESET;
			en_q  <= 4'd0;
			bar_q <= 8'd0;
		end else if (step.scan) begin
			seg_q <= dcss_pkg::seg_pattern(digit);
			en_q  <= onehot;
			bar_q <= step.sample[9:2];
			pos_q <= (pos_q == dcss_pkg::POS_LAST) ? '0 : pos_q + 1'b1;
		end
	end

	assign segments     = seg_q;
	assign digit_enable = en_q;
	assign level_bar    = bar_q;

endmodule

@@ rtl/core/down_counter_seven_segment_scan.sv @@
// Top level of the scanned seven-segment down counter.
// Depends on dcss_pkg, dcss_timer and dcss_scan.
//
// Usage:
// The cmd channel carries one item per transfer: a timer tick (opcode OP_TICK)
// or a display scan step with an ADC sample (opcode OP_SCAN). The res channel
// returns exactly one result per item, showing the segment pattern, the
// one-hot digit enable, the level bar and the counter value after that item.
// The result of an item accepted at a clock edge is valid from that edge on.
// Throughput is one item per cycle while the receiver takes each result; the state registers
// act as the result register, so a new item is taken in the same cycle as
// the previous result is taken. When the receiver stalls, the result holds
// and cmd_ready falls until the result is taken.
// Reset loads the timer with 15535, the counter with 9999, the period with
// 50000, the segments with the pattern for zero, all digits off, a level bar
// of zero and the ones digit as the next scan position; no result is pending.
module down_counter_seven_segment_scan (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  dcss_pkg::cmd_t cmd,
	output logic           res_valid,
	input  logic           res_ready,
	output dcss_pkg::res_t res
);

	logic            res_valid_q;
	logic            accept;
	dcss_pkg::step_t step;
	dcss_pkg::bcd_t  digits;

	assign cmd_ready = !res_valid_q || res_ready;
	assign accept    = cmd_valid && cmd_ready;

	assign step.tick   = accept && (cmd.opcode == dcss_pkg::OP_TICK);
	assign step.scan   = accept && (cmd.opcode == dcss_pkg::OP_SCAN);
	assign step.sample = cmd.adc_sample;

	dcss_timer u_timer (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.count_value (res.count_value),
		.digits      (digits)
	);

	dcss_scan u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.digits       (digits),
		.segments     (res.segments),
		.digit_enable (res.digit_enable),
		.level_bar    (res.level_bar)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;

endmodule

@@ rtl/core/dcss_checker.sv @@
// Port-level checker for the scanned seven-segment down counter, bound to
// the top level. Depends on dcss_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dcss_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           cmd_valid,
	input logic           cmd_ready,
	input dcss_pkg::cmd_t cmd,
	input logic           res_valid,
	input logic           res_ready,
	input dcss_pkg::res_t res
);

	logic cmd_xfer;
	logic tick_xfer;
	logic scan_xfer;

	assign cmd_xfer  = cmd_valid && cmd_ready;
	assign tick_xfer = cmd_xfer && (cmd.opcode == dcss_pkg::OP_TICK);
	assign scan_xfer = cmd_xfer && (cmd.opcode == dcss_pkg::OP_SCAN);

	`ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res), "result changed while stalled")
	`ASSERT_NEXT(a_res_follows, clk, arst_n, cmd_xfer, res_valid, "no result after a transfer")
	`ASSERT_NEXT(a_count_on_tick, clk, arst_n, !tick_xfer, $stable(res.count_value), "count moved without a tick")
	`ASSERT_NEXT(a_scan_bar, clk, arst_n, scan_xfer, res.level_bar == $past(cmd.adc_sample[9:2]) && $onehot0(res.digit_enable), "scan result wrong")
	`ASSERT_IMPL(a_ready_free, clk, arst_n, !res_valid, cmd_ready, "not ready with no result pending")

endmodule

bind down_counter_seven_segment_scan dcss_checker u_dcss_checker (.*);

@@ tb/sv/down_counter_seven_segment_scan_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the scanned seven-segment down counter: a directed
// table, then random ticks and scans, held to fixed results or a predictor
// of the counter, timer and display state. Depends on dcss_pkg and the RTL.
module down_counter_seven_segment_scan_test;

	localparam int TIMEOUT_NS   = 20_000_000;
	localparam int RANDOM_ITEMS = 1928;
	localparam int END_CYCLES   = 8;

	localparam logic [6:0] DIGIT_SEGS [10] = '{
		7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
	};

	typedef struct packed {
		dcss_pkg::opcode_t kind;
		logic [9:0]        sample;
		logic              typed;
		dcss_pkg::res_t    want;
	} directed_row_t;

	localparam directed_row_t DIRECTED [22] = '{
		'{dcss_pkg::OP_TICK, 10'd0,    1'b1, '{7'h3F, 4'h0, 8'd0,   16'd9999}},
		'{dcss_pkg::OP_SCAN, 10'd0,    1'b1, '{7'h6F, 4'h8, 8'd0,   16'd9999}},
		'{dcss_pkg::OP_SCAN, 10'd1023, 1'b1, '{7'h6F, 4'h4, 8'd255, 16'd9999}},
		'{dcss_pkg::OP_SCAN, 10'd100,  1'b1, '{7'h6F, 4'h2, 8'd25,  16'd9999}},
		'{dcss_pkg::OP_SCAN, 10'd101,  1'b1, '{7'h6F, 4'h1, 8'd25,  16'd9999}},
		'{dcss_pkg::OP_SCAN, 10'd900,  1'b1, '{7'h6F, 4'h8, 8'd225, 16'd9999}},
		'{dcss_pkg::OP_SCAN, 10'd901,  1'b1, '{7'h6F, 4'h4, 8'd225, 16'd9999}},
		'{dcss_pkg::OP_SCAN, 10'd200,  1'b0, '0},
		'{dcss_pkg::OP_SCAN, 10'd201,  1'b0, '0},
		'{dcss_pkg::OP_SCAN, 10'd300,  1'b0, '0},
		'{dcss_pkg::OP_SCAN, 10'd301,  1'b0, '0},
		'{dcss_pkg::OP_SCAN, 10'd400,  1'b0, '0},
		'{dcss_pkg::OP_SCAN, 10'd401,  1'b0, '0},
		'{dcss_pkg::OP_SCAN, 10'd500,  1'b0, '0},
		'{dcss_pkg::OP_SCAN, 10'd501,  1'b0, '0},
		'{dcss_pkg::OP_SCAN, 10'd600,  1'b0, '0},
		'{dcss_pkg::OP_SCAN, 10'd601,  1'b0, '0},
		'{dcss_pkg::OP_SCAN, 10'd700,  1'b0, '0},
		'{dcss_pkg::OP_SCAN, 10'd701,  1'b0, '0},
		'{dcss_pkg::OP_SCAN, 10'd800,  1'b0, '0},
		'{dcss_pkg::OP_SCAN, 10'd801,  1'b0, '0},
		'{dcss_pkg::OP_TICK, 10'd1023, 1'b0, '0}
	};

	logic           clk = 1'b0;
	logic           arst_n;
	logic           cmd_valid;
	logic           cmd_ready;
	dcss_pkg::cmd_t cmd;
	logic           res_valid;
	logic           res_ready;
	dcss_pkg::res_t res;

	logic [15:0] tmr_q;
	logic [15:0] count_q;
	logic [15:0] period_q;
	int unsigned scan_pos;
	logic [6:0]  seg_q;
	logic [3:0]  enable_q;
	logic [7:0]  bar_q;

	dcss_pkg::res_t pending_display [$];
	dcss_pkg::res_t oldest_display;
	int             errors;

	down_counter_seven_segment_scan dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	always #5 clk = ~clk;

	function automatic dcss_pkg::res_t step_counter_display(input dcss_pkg::cmd_t c);
		int unsigned    bucket;
		int unsigned    divisor;
		dcss_pkg::res_t r;
		if (c.opcode == dcss_pkg::OP_TICK) begin
			if (tmr_q == 16'hFFFF) begin
				tmr_q   = 16'hFFFF - period_q;
				count_q = count_q - 16'd1;
			end else begin
				tmr_q = tmr_q + 16'd1;
			end
		end else begin
			bucket = (c.adc_sample == 10'd0) ? 0 : (int'(c.adc_sample) - 1) / 100;
			if (bucket > 9)
				bucket = 9;
			period_q = 16'(5000 * (bucket + 1));
			bar_q    = c.adc_sample[9:2];
			divisor  = 1;
			repeat (scan_pos) divisor = divisor * 10;
			seg_q    = DIGIT_SEGS[(int'(count_q) / divisor) % 10];
			enable_q = 4'(1 << (dcss_pkg::NUM_DIGITS - 1 - scan_pos));
			scan_pos = (scan_pos + 1) % dcss_pkg::NUM_DIGITS;
		end
		r.segments     = seg_q;
		r.digit_enable = enable_q;
		r.level_bar    = bar_q;
		r.count_value  = count_q;
		return r;
	endfunction

	task automatic check_field(input string field, input logic [15:0] want,
			input logic [15:0] got);
		if (want != got) begin
			errors++;
			$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
		end
	endtask

	task automatic transfer_cmd(input dcss_pkg::cmd_t c, input bit typed,
			input dcss_pkg::res_t want);
		int             gap;
		dcss_pkg::res_t predicted;
		gap = $urandom_range(0, 5);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		@(negedge clk);
		while (!cmd_ready) @(negedge clk);
		@(posedge clk);
		predicted = step_counter_display(c);
		pending_display.push_back(typed ? want : predicted);
	endtask

	initial begin
		int unsigned stall;
		res_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = $urandom_range(0, 5);
			if (stall > 0) begin
				res_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ready <= 1'b1;
			@(negedge clk);
			while (!res_valid) @(negedge clk);
			@(posedge clk);
		end
	end

	always @(negedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (pending_display.size() == 0) begin
				errors++;
				$display("%0t: result %h arrived with none expected", $time, res);
			end else begin
				oldest_display = pending_display.pop_front();
				check_field("segments", 16'(oldest_display.segments),
					16'(res.segments));
				check_field("digit_enable", 16'(oldest_display.digit_enable),
					16'(res.digit_enable));
				check_field("level_bar", 16'(oldest_display.level_bar),
					16'(res.level_bar));
				check_field("count_value", oldest_display.count_value, res.count_value);
			end
		end
	end

	initial begin
		dcss_pkg::cmd_t c;
		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		cmd       = '0;
		errors    = 0;
		tmr_q     = dcss_pkg::TIMER_RESET;
		count_q   = dcss_pkg::COUNT_RESET;
		period_q  = dcss_pkg::PERIOD_RESET;
		scan_pos  = 0;
		seg_q     = dcss_pkg::SEG_RESET;
		enable_q  = 4'h0;
		bar_q     = 8'd0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			c.opcode     = DIRECTED[i].kind;
			c.adc_sample = DIRECTED[i].sample;
			transfer_cmd(c, DIRECTED[i].typed, DIRECTED[i].want);
		end

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			c.opcode     = $urandom_range(0, 1) ? dcss_pkg::OP_SCAN : dcss_pkg::OP_TICK;
			c.adc_sample = $urandom_range(0, 1) ? 10'($urandom_range(0, 1023))
				: 10'($urandom_range(0, 10) * 100 + $urandom_range(0, 1));
			transfer_cmd(c, 1'b0, '0);
		end
		cmd_valid <= 1'b0;

		while (pending_display.size() != 0) @(posedge clk);
		repeat (END_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("%0t: run timed out", $time);
		$display("FAILED: results differ");
		$finish;
	end

endmodule
